// ===== rtl/egcd_pkg.sv =====
// Shared command and status types for the extended gcd controller and datapath.
package egcd_pkg;

	typedef struct packed {
		logic load;     // take a new operand pair
		logic init;     // start one remainder step
		logic align;    // shift divisor left by one
		logic sub;      // one shift-subtract quotient bit
		logic capture;  // move result into the output word register
	} egcd_cmd_t;

	typedef struct packed {
		logic r1_zero;     // current divisor is zero, recurrence finished
		logic align_more;  // doubled divisor still fits under the remainder
		logic cnt_zero;    // last quotient bit of this step
	} egcd_sts_t;

endpackage

// ===== rtl/egcd_ctrl.sv =====
// Controller state machine for the extended gcd block.
module egcd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output egcd_pkg::egcd_cmd_t cmd,
	input  egcd_pkg::egcd_sts_t sts
);
	import egcd_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CHECK = 5'b00010,
		ST_ALIGN = 5'b00100,
		ST_SUB   = 5'b01000,
		ST_DONE  = 5'b10000
	} egcd_state_t;

	egcd_state_t state_q, state_d;
	logic        out_valid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.r1_zero) begin
					state_d = ST_DONE;
				end else begin
					cmd.init = 1'b1;
					state_d  = ST_ALIGN;
				end
			end
			ST_ALIGN: begin
				if (sts.align_more) begin
					cmd.align = 1'b1;
				end else begin
					state_d = ST_SUB;
				end
			end
			ST_SUB: begin
				cmd.sub = 1'b1;
				if (sts.cnt_zero) begin
					state_d = ST_CHECK;
				end
			end
			ST_DONE: begin
				// output register free or draining this cycle
				if (!out_valid_q || m_tready) begin
					cmd.capture = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/egcd_dp.sv =====
// Datapath for the extended gcd block: remainders, coefficients, shift-subtract divider.
module egcd_dp #(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  egcd_pkg::egcd_cmd_t        cmd,
	output egcd_pkg::egcd_sts_t        sts,
	input  logic [OPERAND_WIDTH-2:0]   operand_a,
	input  logic [OPERAND_WIDTH-2:0]   operand_b,
	output logic [OPERAND_WIDTH-2:0]   divisor,
	output logic [OPERAND_WIDTH-1:0]   coef_a,
	output logic [OPERAND_WIDTH-1:0]   coef_b
);
	import egcd_pkg::*;

	localparam int W  = OPERAND_WIDTH;
	localparam int N  = OPERAND_WIDTH - 1;
	localparam int CW = $clog2(N);

	logic [N-1:0]  r0_q, r1_q, rem_q, dsh_q;
	logic [W-1:0]  x0_q, x1_q, y0_q, y1_q, px_q, py_q;
	logic [CW-1:0] cnt_q;
	logic [N-1:0]  div_q;
	logic [W-1:0]  coefa_q, coefb_q;

	logic          ge;
	logic [N-1:0]  rem_nx;
	logic [W-1:0]  px_nx, py_nx;

	// quotient bits arrive MSB first, so products build up by Horner
	assign ge     = (rem_q >= dsh_q);
	assign rem_nx = ge ? (rem_q - dsh_q) : rem_q;
	assign px_nx  = {px_q[W-2:0], 1'b0} + (ge ? x1_q : '0);
	assign py_nx  = {py_q[W-2:0], 1'b0} + (ge ? y1_q : '0);

	assign sts.r1_zero    = (r1_q == '0);
	assign sts.align_more = ({dsh_q, 1'b0} <= {1'b0, rem_q});
	assign sts.cnt_zero   = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r0_q <= operand_a;
			r1_q <= operand_b;
			x0_q <= W'(1);
			x1_q <= '0;
			y0_q <= '0;
			y1_q <= W'(1);
		end
		if (cmd.init) begin
			rem_q <= r0_q;
			dsh_q <= r1_q;
			cnt_q <= '0;
			px_q  <= '0;
			py_q  <= '0;
		end
		if (cmd.align) begin
			dsh_q <= {dsh_q[N-2:0], 1'b0};
			cnt_q <= cnt_q + CW'(1);
		end
		if (cmd.sub) begin
			rem_q <= rem_nx;
			dsh_q <= {1'b0, dsh_q[N-1:1]};
			cnt_q <= cnt_q - CW'(1);
			px_q  <= px_nx;
			py_q  <= py_nx;
			if (sts.cnt_zero) begin
				r0_q <= r1_q;
				r1_q <= rem_nx;
				x0_q <= x1_q;
				x1_q <= x0_q - px_nx;
				y0_q <= y1_q;
				y1_q <= y0_q - py_nx;
			end
		end
		if (cmd.capture) begin
			div_q   <= r0_q;
			coefa_q <= x0_q;
			coefb_q <= y0_q;
		end
	end

	assign divisor = div_q;
	assign coef_a  = coefa_q;
	assign coef_b  = coefb_q;

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.init, cmd.align, cmd.sub, cmd.capture}))
		else $error("more than one datapath command at once");

	a_sub_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sub |-> (dsh_q != '0))
		else $error("shift-subtract with zero divisor");

	a_align_fits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.align |-> (dsh_q <= rem_q))
		else $error("divisor aligned past the remainder");

	a_rem_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sub && sts.cnt_zero) |=> (r1_q < $past(r1_q)))
		else $error("remainder did not drop below divisor");

endmodule

// ===== rtl/extended_gcd_bezout.sv =====
// Top level of the extended gcd block with Bezout coefficients.
//
// channel  dir  fields (low bit first)
// s_*      in   tdata: operand_a, operand_b
// m_*      out  tdata: divisor, coef_a, coef_b
//
// One word in, one word out, one operand pair at a time. Each remainder step
// passes through check, align and shift-subtract, and each pair also passes
// through load, a final check and output; the shift-subtract divider sets the
// pace. Operands are 31 bits wide at the default width.
// Asynchronous reset clears the controller and the output valid.
// A stalled output word holds; a new pair is taken while it waits.
module extended_gcd_bezout #(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [((2*(OPERAND_WIDTH-1)+7)/8)*8-1:0] s_tdata,  // operand_a, operand_b
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [((3*OPERAND_WIDTH-1+7)/8)*8-1:0]   m_tdata   // divisor, coef_a, coef_b
);
	import egcd_pkg::*;

	localparam int N  = OPERAND_WIDTH - 1;
	localparam int W  = OPERAND_WIDTH;
	localparam int DW = ((3*OPERAND_WIDTH-1+7)/8)*8;

	egcd_cmd_t     cmd;
	egcd_sts_t     sts;
	logic [N-1:0]  divisor;
	logic [W-1:0]  coef_a, coef_b;

	egcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	egcd_dp #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.operand_a (s_tdata[N-1:0]),
		.operand_b (s_tdata[2*N-1:N]),
		.divisor   (divisor),
		.coef_a    (coef_a),
		.coef_b    (coef_b)
	);

	assign m_tdata = DW'({coef_b, coef_a, divisor});

endmodule
